@@ src/prc_pkg.sv @@
`default_nettype none

package prc_pkg;

  localparam int HEADER_BYTES  = 32;
  localparam int PAYLOAD_WORDS = 22;
  localparam int RECORD_BYTES  = HEADER_BYTES + 4 * PAYLOAD_WORDS;

  localparam logic [31:0] REC_MAGIC    = 32'h504C_4F4D;
  localparam logic [31:0] KNOWN_FLAGS  = 32'h0000_03FF;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [15:0] HEADER_SIZE  = 16'(HEADER_BYTES);
  localparam logic [31:0] PAYLOAD_SIZE = 32'(4 * PAYLOAD_WORDS);

  localparam logic [7:0] HEADER_END = 8'(HEADER_BYTES);
  localparam logic [7:0] RECORD_END = 8'(RECORD_BYTES);
  localparam logic [7:0] LAST_POS   = 8'(RECORD_BYTES - 1);
  localparam logic [7:0] COUNT_MAX  = 8'hFF;
  localparam logic [6:0] PAYLOAD_BASE = 7'(HEADER_BYTES);

  // header word positions
  localparam logic [2:0] HW_MAGIC   = 3'd0;
  localparam logic [2:0] HW_SIZES   = 3'd1;
  localparam logic [2:0] HW_PAYLOAD = 3'd2;
  localparam logic [2:0] HW_FLAGS   = 3'd3;
  localparam logic [2:0] HW_HASH    = 3'd4;
  localparam logic [2:0] HW_CRC     = 3'd5;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INVALID     = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [7:0]  byte_count;
    logic [31:0] running_crc;
    logic [31:0] word_shift;
    logic        layout_error;
    logic [15:0] version_seen;
    logic [31:0] flags_seen;
    logic [31:0] hash_seen;
    logic [31:0] stored_crc;
    logic        range_error;
  } rec_state_t;

  localparam rec_state_t REC_STATE_RESET = '{
    byte_count:   8'd0,
    running_crc:  32'hFFFF_FFFF,
    word_shift:   32'd0,
    layout_error: 1'b0,
    version_seen: 16'd0,
    flags_seen:   32'd0,
    hash_seen:    32'd0,
    stored_crc:   32'd0,
    range_error:  1'b0
  };

  typedef struct packed {
    logic        result_kind;
    logic [4:0]  word_index;
    logic [31:0] word_value;
    logic [1:0]  status;
    logic [31:0] feature_bits;
    logic [31:0] preset_hash;
    logic        final_result;
  } result_t;

  // reflected crc-32, one byte, bit loop unrolled
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic signed [31:0] lim_lo(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd2:    v = -32'sd24000;
      5'd6:    v = 32'sd1;
      5'd7:    v = 32'sd20;
      5'd10:   v = -32'sd1200;
      5'd11:   v = 32'sd50;
      5'd16:   v = 32'sd100;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] lim_hi(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0, 5'd1:                  v = 32'sd5;
      5'd2:                        v = 32'sd6000;
      5'd3, 5'd4, 5'd18:           v = 32'sd10000;
      5'd6, 5'd7, 5'd12, 5'd13,
      5'd14:                       v = 32'sd20000;
      5'd8:                        v = 32'sd990;
      5'd10:                       v = 32'sd1200;
      5'd11:                       v = 32'sd950;
      5'd15:                       v = 32'sd200;
      5'd16:                       v = 32'sd3000;
      default:                     v = 32'sd1000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ src/prc_step.sv @@
`default_nettype none

module prc_step (
  input  prc_pkg::rec_state_t cur,
  input  logic [7:0]          byte_in,
  input  logic                last_in,
  input  logic [15:0]         expected_version,
  output prc_pkg::rec_state_t nxt,
  output prc_pkg::result_t    word_res,
  output logic                word_emit,
  output prc_pkg::result_t    status_res,
  output logic                status_emit
);
  import prc_pkg::*;

  logic [31:0]        shift_n;
  logic [6:0]         off;
  logic [4:0]         wi;
  logic signed [31:0] v;
  logic [31:0]        crc_fin;
  logic [1:0]         st;
  rec_state_t         upd;

  always_comb begin
    upd         = cur;
    word_res    = '0;
    word_emit   = 1'b0;
    shift_n     = {byte_in, cur.word_shift[31:8]};
    upd.word_shift = shift_n;
    off         = cur.byte_count[6:0] - PAYLOAD_BASE;
    wi          = off[6:2];
    v           = $signed(shift_n);

    if (cur.byte_count < HEADER_END) begin
      if (cur.byte_count[1:0] == 2'd3) begin
        case (cur.byte_count[4:2])
          HW_MAGIC: begin
            if (shift_n != REC_MAGIC) upd.layout_error = 1'b1;
          end
          HW_SIZES: begin
            upd.version_seen = shift_n[15:0];
            if (shift_n[31:16] != HEADER_SIZE) upd.layout_error = 1'b1;
          end
          HW_PAYLOAD: begin
            if (shift_n != PAYLOAD_SIZE) upd.layout_error = 1'b1;
          end
          HW_FLAGS: upd.flags_seen = shift_n;
          HW_HASH:  upd.hash_seen  = shift_n;
          HW_CRC:   upd.stored_crc = shift_n;
          default: begin
            // reserved words
            if (shift_n != 32'd0) upd.layout_error = 1'b1;
          end
        endcase
      end
    end else if (cur.byte_count < RECORD_END) begin
      upd.running_crc = crc_byte(cur.running_crc, byte_in);
      if (off[1:0] == 2'd3) begin
        if (v < lim_lo(wi) || v > lim_hi(wi)) upd.range_error = 1'b1;
        word_res.result_kind = KIND_WORD;
        word_res.word_index  = wi;
        word_res.word_value  = shift_n;
        word_emit            = 1'b1;
      end
    end

    if (cur.byte_count != COUNT_MAX) upd.byte_count = cur.byte_count + 8'd1;
  end

  // status from the state as left by this word
  always_comb begin
    crc_fin = ~upd.running_crc;
    if (cur.byte_count != LAST_POS || upd.layout_error) begin
      st = ST_INVALID;
    end else if (upd.version_seen != expected_version) begin
      st = ST_UNSUPPORTED;
    end else if ((upd.flags_seen & ~KNOWN_FLAGS) != 32'd0 || upd.stored_crc != crc_fin ||
                 upd.hash_seen == 32'd0 || upd.range_error) begin
      st = ST_INVALID;
    end else begin
      st = ST_OK;
    end

    status_res              = '0;
    status_res.result_kind  = KIND_STATUS;
    status_res.status       = st;
    status_res.feature_bits = upd.flags_seen;
    status_res.preset_hash  = upd.hash_seen;
    status_res.final_result = 1'b1;
    status_emit             = last_in;
    nxt                     = last_in ? REC_STATE_RESET : upd;
  end

endmodule

`default_nettype wire

@@ src/prc_out_fifo.sv @@
`default_nettype none

module prc_out_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [1:0]                     push_cnt,
  input  prc_pkg::result_t               push0,
  input  prc_pkg::result_t               push1,
  input  logic                           pop,
  output prc_pkg::result_t               head,
  output logic [prc_pkg::OUT_CNT_W-1:0]  cnt
);
  import prc_pkg::*;

  result_t              mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUT_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OUT_PTR_W-1:0] wr_ptr_p1;

  always_comb begin
    wr_ptr_p1  = wr_ptr_r + OUT_PTR_W'(1);
    wr_ptr_nxt = wr_ptr_r + OUT_PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + OUT_PTR_W'(pop);
    cnt_nxt    = cnt_r + OUT_CNT_W'(push_cnt) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_ptr_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wr_ptr_p1] <= push1;
  end

  assign head = mem_r[rd_ptr_r];
  assign cnt  = cnt_r;

endmodule

`default_nettype wire

@@ src/patch_record_checker_unit.sv @@
// patch record checker
// in channel: one record byte per word (in_byte_value), in_last_byte on the final one.
// out channel: a payload word result for every completed payload word (22 per
// well-formed record), and one status result after the last byte, marked by
// out_final_result. A last byte that completes word 21 gives both, word first.
// cfg channel: cfg_data sets the expected format version; write only while idle.
// results are written into the result queue as their byte is accepted.
// throughput: one byte per cycle while in_ready is high; the crc byte step and
// the word range compare sit between the state registers and a four-entry
// result queue. in_ready drops while fewer than two queue entries are free, so
// a stalled receiver backs the byte stream up once the queue holds more than two
// results; nothing is dropped. cfg_ready is always high.
// reset: synchronous, active low; clears the record state, empties the queue and
// sets the expected version to 1. after every status the record state clears
// on its own, ready for the next record.
`default_nettype none

module patch_record_checker_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte_value,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_result_kind,
  output logic [4:0]         out_word_index,
  output logic signed [31:0] out_word_value,
  output logic [1:0]         out_status,
  output logic [31:0]        out_feature_bits,
  output logic [31:0]        out_preset_hash,
  output logic               out_final_result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import prc_pkg::*;

  rec_state_t           state_r, state_nxt;
  logic [15:0]          version_r;
  result_t              word_res, status_res, head;
  logic                 word_emit, status_emit;
  logic                 in_acc;
  logic [1:0]           push_cnt;
  result_t              push0;
  logic [OUT_CNT_W-1:0] q_cnt;

  assign cfg_ready = 1'b1;
  assign in_ready  = (q_cnt <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= 16'd1;
    end else if (cfg_valid) begin
      version_r <= cfg_data;
    end
  end

  prc_step u_step (
    .cur              (state_r),
    .byte_in          (in_byte_value),
    .last_in          (in_last_byte),
    .expected_version (version_r),
    .nxt              (state_nxt),
    .word_res         (word_res),
    .word_emit        (word_emit),
    .status_res       (status_res),
    .status_emit      (status_emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= REC_STATE_RESET;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    push_cnt = in_acc ? (2'(word_emit) + 2'(status_emit)) : 2'd0;
    push0    = word_emit ? word_res : status_res;
  end

  prc_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .push0    (push0),
    .push1    (status_res),
    .pop      (out_valid && out_ready),
    .head     (head),
    .cnt      (q_cnt)
  );

  assign out_valid        = (q_cnt != '0);
  assign out_result_kind  = head.result_kind;
  assign out_word_index   = head.word_index;
  assign out_word_value   = $signed(head.word_value);
  assign out_status       = head.status;
  assign out_feature_bits = head.feature_bits;
  assign out_preset_hash  = head.preset_hash;
  assign out_final_result = head.final_result;

`ifndef SYNTHESIS
  a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result queue overfilled");

  a_clear_after_last : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_byte) |=> (state_r.byte_count == 8'd0))
    else $error("record state not cleared after last byte");

  a_word_has_index : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_WORD) |->
      (out_word_index <= 5'(PAYLOAD_WORDS - 1) && !out_final_result))
    else $error("bad payload word result");

  a_accept_needs_room : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (word_emit || in_last_byte)) |=> (q_cnt != '0))
    else $error("queue empty after producing result");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none

module tb_top;
  import prc_pkg::*;

  typedef enum int {
    DEF_MAGIC, DEF_HDR_SIZE, DEF_PAY_SIZE, DEF_RESERVED, DEF_VERSION,
    DEF_FLAGS, DEF_HASH, DEF_CRC, DEF_RANGE, DEF_PAYLOAD_BIT, DEF_COUNT
  } defect_e;

  typedef enum int {FILL_RANDOM, FILL_MIN, FILL_MAX} fill_e;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_byte_value;
  logic in_last_byte;
  logic out_valid;
  logic out_ready;
  logic out_result_kind;
  logic [4:0] out_word_index;
  logic signed [31:0] out_word_value;
  logic [1:0] out_status;
  logic [31:0] out_feature_bits;
  logic [31:0] out_preset_hash;
  logic out_final_result;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_data;

  patch_record_checker_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_value    (in_byte_value),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_word_index   (out_word_index),
    .out_word_value   (out_word_value),
    .out_status       (out_status),
    .out_feature_bits (out_feature_bits),
    .out_preset_hash  (out_preset_hash),
    .out_final_result (out_final_result),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  // per-field inclusive limits of the payload words
  int field_min[PAYLOAD_WORDS] = '{
    0, 0, -24000, 0, 0, 0, 1, 20, 0, 0, -1200,
    50, 0, 0, 0, 0, 100, 0, 0, 0, 0, 0};
  int field_max[PAYLOAD_WORDS] = '{
    5, 5, 6000, 10000, 10000, 1000, 20000, 20000, 990, 1000, 1200,
    950, 20000, 20000, 20000, 200, 3000, 1000, 10000, 1000, 1000, 1000};

  // decoder state as the block should hold it
  logic [15:0] cfg_version;
  logic [7:0]  rec_pos;
  logic [31:0] shift_reg;
  logic [31:0] crc_acc;
  logic        hdr_bad;
  logic [15:0] ver_got;
  logic [31:0] flags_got;
  logic [31:0] hash_got;
  logic [31:0] crc_stored;
  logic        value_bad;

  result_t     results_due[$];
  logic [7:0]  rec_bytes[$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  bit          no_gaps = 1'b0;

  function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] data);
    logic [31:0] c;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ data[i]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic int unsigned draw_wait();
    if (no_gaps) return 0;
    case ($urandom_range(0, 3))
      0, 1: return 0;
      2: return $urandom_range(1, 3);
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic void clear_record_state();
    rec_pos    = '0;
    shift_reg  = '0;
    crc_acc    = '1;
    hdr_bad    = 1'b0;
    ver_got    = '0;
    flags_got  = '0;
    hash_got   = '0;
    crc_stored = '0;
    value_bad  = 1'b0;
  endfunction

  // advance the decoder by one accepted byte and queue the results it causes
  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [7:0] pos;
    logic [7:0] off;
    logic [4:0] widx;
    logic [1:0] st;
    result_t r;
    pos = rec_pos;
    shift_reg = {b, shift_reg[31:8]};
    if (pos < HEADER_END) begin
      if (pos[1:0] == 2'd3) begin
        case (pos[4:2])
          HW_MAGIC: if (shift_reg != REC_MAGIC) hdr_bad = 1'b1;
          HW_SIZES: begin
            ver_got = shift_reg[15:0];
            if (shift_reg[31:16] != HEADER_SIZE) hdr_bad = 1'b1;
          end
          HW_PAYLOAD: if (shift_reg != PAYLOAD_SIZE) hdr_bad = 1'b1;
          HW_FLAGS: flags_got = shift_reg;
          HW_HASH: hash_got = shift_reg;
          HW_CRC: crc_stored = shift_reg;
          default: if (shift_reg != '0) hdr_bad = 1'b1;
        endcase
      end
    end else if (pos < RECORD_END) begin
      crc_acc = crc32_update(crc_acc, b);
      off = pos - HEADER_END;
      if (off[1:0] == 2'd3) begin
        widx = off[6:2];
        if ($signed(shift_reg) < field_min[widx] || $signed(shift_reg) > field_max[widx])
          value_bad = 1'b1;
        r = '0;
        r.result_kind = KIND_WORD;
        r.word_index  = widx;
        r.word_value  = shift_reg;
        results_due.push_back(r);
      end
    end
    if (rec_pos != COUNT_MAX) rec_pos = rec_pos + 8'd1;
    if (last) begin
      if (pos != LAST_POS || hdr_bad)
        st = ST_INVALID;
      else if (ver_got != cfg_version)
        st = ST_UNSUPPORTED;
      else if ((flags_got & ~KNOWN_FLAGS) != '0 || crc_stored != ~crc_acc ||
               hash_got == '0 || value_bad)
        st = ST_INVALID;
      else
        st = ST_OK;
      r = '0;
      r.result_kind  = KIND_STATUS;
      r.status       = st;
      r.feature_bits = flags_got;
      r.preset_hash  = hash_got;
      r.final_result = 1'b1;
      results_due.push_back(r);
      clear_record_state();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result expected none got kind %0d index %0d value %h status %0d",
                 $time, out_result_kind, out_word_index, out_word_value, out_status);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("result_kind", want.result_kind, out_result_kind);
        check_field("word_index", want.word_index, out_word_index);
        check_field("word_value", want.word_value, out_word_value);
        check_field("status", want.status, out_status);
        check_field("feature_bits", want.feature_bits, out_feature_bits);
        check_field("preset_hash", want.preset_hash, out_preset_hash);
        check_field("final_result", want.final_result, out_final_result);
      end
    end
  end

  // receiver: random stall before each result word
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    forever begin
      stall = draw_wait();
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // valid stays up after the handshake so back-to-back words need no second edit
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_value <= b;
    in_last_byte  <= last;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, last);
  endtask

  task automatic send_record();
    for (int i = 0; i < rec_bytes.size(); i++)
      send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
    bytes_sent += rec_bytes.size();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_version(input logic [15:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_version = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic put_word(input int at, input logic [31:0] w);
    for (int k = 0; k < 4; k++) rec_bytes[at + k] = w[8*k +: 8];
  endtask

  task automatic seal_payload();
    logic [31:0] c;
    c = '1;
    for (int i = HEADER_BYTES; i < RECORD_BYTES; i++) c = crc32_update(c, rec_bytes[i]);
    put_word(20, ~c);
  endtask

  task automatic set_payload_word(input int idx, input logic [31:0] v);
    put_word(HEADER_BYTES + 4 * idx, v);
    seal_payload();
  endtask

  task automatic build_record(input logic [15:0] ver, input fill_e fill);
    logic [31:0] h;
    int v;
    rec_bytes.delete();
    repeat (RECORD_BYTES) rec_bytes.push_back(8'h00);
    put_word(0, REC_MAGIC);
    put_word(4, {HEADER_SIZE, ver});
    put_word(8, PAYLOAD_SIZE);
    put_word(12, $urandom & KNOWN_FLAGS);
    h = $urandom;
    if (h == '0) h = 32'd1;
    put_word(16, h);
    for (int w = 0; w < PAYLOAD_WORDS; w++) begin
      case (fill)
        FILL_MIN: v = field_min[w];
        FILL_MAX: v = field_max[w];
        default: v = field_min[w] + $urandom_range(0, field_max[w] - field_min[w]);
      endcase
      put_word(HEADER_BYTES + 4 * w, v);
    end
    seal_payload();
  endtask

  task automatic resize_record(input int n);
    while (rec_bytes.size() > n) void'(rec_bytes.pop_back());
    while (rec_bytes.size() < n) rec_bytes.push_back(8'($urandom));
  endtask

  task automatic break_record(input defect_e d);
    int i;
    int w;
    logic [15:0] s;
    logic [31:0] v;
    case (d)
      DEF_MAGIC: begin
        i = $urandom_range(0, 3);
        rec_bytes[i] = rec_bytes[i] ^ 8'(1 << $urandom_range(0, 7));
      end
      DEF_HDR_SIZE: begin
        s = 16'($urandom);
        if (s == HEADER_SIZE) s = ~s;
        rec_bytes[6] = s[7:0];
        rec_bytes[7] = s[15:8];
      end
      DEF_PAY_SIZE: begin
        v = $urandom;
        if (v == PAYLOAD_SIZE) v = '0;
        put_word(8, v);
      end
      DEF_RESERVED: rec_bytes[$urandom_range(24, 31)] = 8'($urandom_range(1, 255));
      DEF_VERSION: begin
        i = $urandom_range(4, 5);
        rec_bytes[i] = rec_bytes[i] ^ 8'($urandom_range(1, 255));
      end
      DEF_FLAGS: begin
        w = $urandom_range(10, 31);
        rec_bytes[12 + w / 8] = rec_bytes[12 + w / 8] | 8'(1 << (w % 8));
      end
      DEF_HASH: put_word(16, 32'd0);
      DEF_CRC: begin
        i = $urandom_range(20, 23);
        rec_bytes[i] = rec_bytes[i] ^ 8'(1 << $urandom_range(0, 7));
      end
      DEF_RANGE: begin
        w = $urandom_range(0, PAYLOAD_WORDS - 1);
        case ($urandom_range(0, 2))
          0: v = field_min[w] - 1;
          1: v = field_max[w] + 1;
          default: v = $urandom;
        endcase
        set_payload_word(w, v);
      end
      DEF_PAYLOAD_BIT: begin
        // crc left stale on purpose
        i = $urandom_range(HEADER_BYTES, RECORD_BYTES - 1);
        rec_bytes[i] = rec_bytes[i] ^ 8'(1 << $urandom_range(0, 7));
      end
      default: ;
    endcase
  endtask

  task automatic test_clean_records();
    build_record(16'd1, FILL_MIN);
    put_word(12, 32'd0);
    put_word(16, 32'd1);
    send_record();
  endtask

  task automatic test_header_layout();
    for (int d = DEF_HDR_SIZE; d <= DEF_RESERVED; d++) begin
      build_record(cfg_version, FILL_RANDOM);
      break_record(defect_e'(d));
      send_record();
    end
    // a layout fault outranks a version mismatch
    build_record(cfg_version, FILL_RANDOM);
    break_record(DEF_MAGIC);
    break_record(DEF_VERSION);
    send_record();
  endtask

  task automatic test_payload_checks();
    for (int d = DEF_FLAGS; d <= DEF_RANGE; d++) begin
      build_record(cfg_version, FILL_RANDOM);
      break_record(defect_e'(d));
      send_record();
    end
  endtask

  task automatic test_record_length();
    build_record(cfg_version, FILL_RANDOM);
    resize_record(1);
    send_record();
    build_record(cfg_version, FILL_RANDOM);
    resize_record(RECORD_BYTES - 1);
    send_record();
    // long enough for the byte counter to saturate
    build_record(cfg_version, FILL_RANDOM);
    resize_record(260);
    send_record();
  endtask

  task automatic test_version_register();
    write_version(16'hFFFF);
    build_record(16'hFFFF, FILL_MAX);
    put_word(12, KNOWN_FLAGS);
    put_word(16, 32'hFFFF_FFFF);
    send_record();
    write_version(16'h0000);
    build_record(16'h0001, FILL_RANDOM);
    send_record();
    write_version(16'd1);
  endtask

  task automatic test_random_records();
    int stop_at;
    int pick;
    logic [15:0] ver;
    stop_at = bytes_sent + 200;
    while (bytes_sent < stop_at) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: write_version(16'h0000);
          1: write_version(16'hFFFF);
          2: write_version(16'd1);
          default: write_version(16'($urandom));
        endcase
      end
      ver = ($urandom_range(0, 9) == 0) ? 16'($urandom) : cfg_version;
      pick = $urandom_range(0, 19);
      build_record(ver, FILL_RANDOM);
      if (pick >= 13 && pick < 16)
        break_record(defect_e'($urandom_range(0, DEF_COUNT - 1)));
      else if (pick == 16 || pick == 17)
        resize_record($urandom_range(0, 1) ? $urandom_range(1, RECORD_BYTES - 1)
                                           : $urandom_range(RECORD_BYTES + 1, 300));
      else if (pick >= 18) begin
        rec_bytes.delete();
        resize_record($urandom_range(1, 140));
      end
      send_record();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    int guard;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_byte_value = '0;
    in_last_byte  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    cfg_version   = 16'd1;
    clear_record_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_clean_records();
    test_header_layout();
    test_payload_checks();
    test_record_length();
    test_version_register();
    test_random_records();

    @(negedge clk);
    in_valid <= 1'b0;
    for (guard = 0; guard < 100000 && results_due.size() != 0; guard++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d results expected got none", $time, results_due.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("patch_record_checker_unit regression: pass");
    else
      $display("patch_record_checker_unit regression: fail");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("patch_record_checker_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
